@@ hw/rtl/lrupr_pkg.sv @@
package lrupr_pkg;

	localparam int CFG_W   = 5;
	localparam int FAULT_W = 32;

	localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = 5'd4;
	localparam logic [FAULT_W-1:0] FAULT_MAX       = '1;

	// status bits of one finished reference
	typedef struct packed {
		logic hit;
		logic evicted_valid;
	} lrupr_flags_t;

endpackage

@@ hw/rtl/lrupr_frame_mem.sv @@
module lrupr_frame_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/lrupr_ctrl.sv @@
module lrupr_ctrl #(
	parameter int FRAMES     = 16,
	parameter int PAGE_WIDTH = 16,
	localparam int AW        = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_fire,
	input  logic [PAGE_WIDTH-1:0]         item_page,
	input  logic                          cfg_fire,
	input  logic [lrupr_pkg::CFG_W-1:0]   cfg_value,
	input  logic [lrupr_pkg::CFG_W-1:0]   frame_count_cur,
	input  logic                          res_free,
	output logic                          idle,
	output logic                          res_valid,
	output lrupr_pkg::lrupr_flags_t       res_flags,
	output logic [PAGE_WIDTH-1:0]         res_ev_page,
	output logic [lrupr_pkg::FAULT_W-1:0] res_faults,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [PAGE_WIDTH-1:0]         mem_wdata,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [PAGE_WIDTH-1:0]         mem_rdata
);

	import lrupr_pkg::*;

	localparam int CW = $clog2(FRAMES + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_SHIFT  = 3'd2;
	localparam logic [2:0] ST_APPEND = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	// clamp the register to 1..FRAMES
	function automatic logic [CW-1:0] eff_cap(input logic [CFG_W-1:0] fc);
		int v;
		v = int'(fc);
		if (v < 1) v = 1;
		if (v > FRAMES) v = FRAMES;
		return CW'(v);
	endfunction

	logic [2:0]            state_q;
	logic [PAGE_WIDTH-1:0] page_q;
	logic [CW-1:0]         resident_q;
	logic [CW-1:0]         idx_q;     // read pointer: scan position or shift source
	logic [CW-1:0]         off_q;     // shift distance
	logic                  cfg_op_q;
	logic                  hit_q;
	logic                  ev_valid_q;
	logic [PAGE_WIDTH-1:0] ev_page_q;
	logic [FAULT_W-1:0]    fault_q;
	logic                  rd_pend_s1;
	logic [CW-1:0]         rd_idx_s1;

	logic [CW-1:0]      cap;
	logic [CW-1:0]      cfg_cap;
	logic               issue;
	logic               match;
	logic               scan_last;
	logic [CW-1:0]      shift_dst;
	logic [FAULT_W-1:0] fault_next;

	assign cap        = eff_cap(frame_count_cur);
	assign cfg_cap    = eff_cap(cfg_value);
	assign issue      = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (idx_q < resident_q);
	assign match      = rd_pend_s1 && (mem_rdata == page_q);
	assign scan_last  = rd_pend_s1 && (rd_idx_s1 == (resident_q - CW'(1)));
	assign shift_dst  = rd_idx_s1 - off_q;
	assign fault_next = (fault_q == FAULT_MAX) ? fault_q : (fault_q + FAULT_W'(1));

	// memory access: reads walk idx_q, each shift write follows its read in the next cycle, when the read data returns
	assign mem_raddr = idx_q[AW-1:0];
	assign mem_we    = ((state_q == ST_SHIFT) && rd_pend_s1) || (state_q == ST_APPEND);
	assign mem_waddr = (state_q == ST_APPEND) ? resident_q[AW-1:0] : shift_dst[AW-1:0];
	assign mem_wdata = (state_q == ST_APPEND) ? page_q : mem_rdata;

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			page_q     <= '0;
			resident_q <= '0;
			idx_q      <= '0;
			off_q      <= '0;
			cfg_op_q   <= 1'b0;
			hit_q      <= 1'b0;
			ev_valid_q <= 1'b0;
			ev_page_q  <= '0;
			fault_q    <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			// a hit drops the read already in flight behind it
			rd_pend_s1 <= issue && !((state_q == ST_SCAN) && match);
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						cfg_op_q <= 1'b1;
						// drop the oldest pages beyond the new limit
						if (resident_q > cfg_cap) begin
							off_q   <= resident_q - cfg_cap;
							idx_q   <= resident_q - cfg_cap;
							state_q <= ST_SHIFT;
						end
					end else if (item_fire) begin
						cfg_op_q   <= 1'b0;
						page_q     <= item_page;
						hit_q      <= 1'b0;
						ev_valid_q <= 1'b0;
						idx_q      <= '0;
						if (resident_q == '0) begin
							fault_q <= fault_next;
							state_q <= ST_APPEND;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_pend_s1 && (rd_idx_s1 == '0)) begin
						ev_page_q <= mem_rdata;
					end
					if (match) begin
						hit_q      <= 1'b1;
						off_q      <= CW'(1);
						idx_q      <= rd_idx_s1 + CW'(1);
						state_q    <= ST_SHIFT;
					end else if (scan_last) begin
						fault_q <= fault_next;
						if (resident_q >= cap) begin
							ev_valid_q <= 1'b1;
							off_q      <= CW'(1);
							idx_q      <= CW'(1);
							state_q    <= ST_SHIFT;
						end else begin
							state_q <= ST_APPEND;
						end
					end else if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_SHIFT: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (!issue && !rd_pend_s1) begin
						resident_q <= resident_q - off_q;
						state_q    <= cfg_op_q ? ST_IDLE : ST_APPEND;
					end
				end
				ST_APPEND: begin
					resident_q <= resident_q + CW'(1);
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle                    = (state_q == ST_IDLE);
	assign res_valid               = (state_q == ST_DONE) && res_free;
	assign res_flags.hit           = hit_q;
	assign res_flags.evicted_valid = ev_valid_q;
	assign res_ev_page             = ev_valid_q ? ev_page_q : '0;
	assign res_faults              = fault_q;

endmodule

@@ hw/rtl/lru_page_replacement_unit.sv @@
// LRU page frame manager, one page reference per transaction, one result each.
// One reference in work at a time: it scans the residents, shifts them on a hit or an
// eviction, and appends the page as most recent; the result shows in the same cycle
// that the next reference can be taken. A frame_count write trimming the residents
// shifts them too, and the block takes nothing else until that is done.
// Reset: residents and fault count clear, frame_count returns to 4, frame memory undefined.
module lru_page_replacement_unit #(
	parameter int FRAMES     = 16,
	parameter int PAGE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// reference input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [PAGE_WIDTH-1:0]         page_number,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic                          evicted_valid,
	output logic [PAGE_WIDTH-1:0]         evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0] fault_count,
	// configuration write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lrupr_pkg::CFG_W-1:0]   frame_count
);

	import lrupr_pkg::*;

	localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [CFG_W-1:0]      frame_count_q;
	logic                  ctrl_idle;
	logic                  res_valid;
	logic                  res_free;
	lrupr_flags_t          res_flags;
	logic [PAGE_WIDTH-1:0] res_ev_page;
	logic [FAULT_W-1:0]    res_faults;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [PAGE_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]         mem_raddr;
	logic [PAGE_WIDTH-1:0] mem_rdata;

	logic                  out_valid_q;
	logic                  hit_q;
	logic                  ev_valid_q;
	logic [PAGE_WIDTH-1:0] ev_page_q;
	logic [FAULT_W-1:0]    faults_q;

	logic in_fire;
	logic cfg_fire;

	// Both ports are served only between references; a pending config write
	// wins over a new reference.
	assign cfg_ready = ctrl_idle;
	assign in_ready  = ctrl_idle && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_fire) begin
			frame_count_q <= frame_count;
		end
	end

	// Output register: a finished result lands here only when the slot is
	// empty or being drained in the same cycle.
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			hit_q      <= res_flags.hit;
			ev_valid_q <= res_flags.evicted_valid;
			ev_page_q  <= res_ev_page;
			faults_q   <= res_faults;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = faults_q;

	// Sequencer: scan for the page, close the gap it leaves (or the evicted
	// oldest slot), then append the page as most recent; a trimming frame_count write shifts out the oldest pages.
	lrupr_ctrl #(
		.FRAMES     (FRAMES),
		.PAGE_WIDTH (PAGE_WIDTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_fire       (in_fire),
		.item_page       (page_number),
		.cfg_fire        (cfg_fire),
		.cfg_value       (frame_count),
		.frame_count_cur (frame_count_q),
		.res_free        (res_free),
		.idle            (ctrl_idle),
		.res_valid       (res_valid),
		.res_flags       (res_flags),
		.res_ev_page     (res_ev_page),
		.res_faults      (res_faults),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_raddr       (mem_raddr),
		.mem_rdata       (mem_rdata)
	);

	// Resident pages in recency order, oldest at address 0.
	lrupr_frame_mem #(
		.DEPTH (FRAMES),
		.AW    (AW),
		.DW    (PAGE_WIDTH)
	) u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// a hit never evicts
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted_valid))
		else $error("hit reported together with an eviction");

	// no eviction means a zero page
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page nonzero without eviction");

	// fault count never goes down from one result to the next
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || (fault_count >= $past(fault_count)))
		else $error("fault count decreased");

endmodule

@@ tb/tb_lru_page_replacement_unit.sv @@
module tb_lru_page_replacement_unit;
	import lrupr_pkg::*;

	localparam int FRAMES       = 16;
	localparam int PAGE_WIDTH   = 16;
	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 8;
	// tail after the last reference: leave room for a stray result
	localparam int TAIL_CYCLES  = 2 * FRAMES + 24;
	// watchdog time limit, well above the slowest clean run
	localparam longint RUN_LIMIT = 64'd400000 * (2 * CLK_HALF);
	localparam int PHASES        = 14;
	localparam int PHASE_REFS    = 105;

	typedef logic [PAGE_WIDTH-1:0] page_t;

	// what one reference is expected to report
	typedef struct {
		lrupr_flags_t       flags;
		page_t              victim;
		logic [FAULT_W-1:0] faults;
	} outcome_t;

	// Scoreboard: keeps its own recency list and fault total, turns every accepted
	// reference into an expected outcome, and checks outcomes in arrival order.
	class lru_frame_board;
		page_t              recency[$];   // [0] is least recent
		logic [CFG_W-1:0]   frames_reg;
		logic [FAULT_W-1:0] fault_total;
		outcome_t           awaited[$];
		int unsigned        failures;

		function new();
			frames_reg  = FRAME_COUNT_RST;
			fault_total = '0;
			failures    = 0;
		endfunction

		// zero behaves as one frame, anything past FRAMES as FRAMES
		function int unsigned capacity();
			if (frames_reg == 0)
				return 1;
			if (frames_reg > FRAMES)
				return FRAMES;
			return int'(frames_reg);
		endfunction

		// shrinking drops the oldest pages silently: no eviction, no fault
		function void note_frame_count(logic [CFG_W-1:0] value);
			frames_reg = value;
			while (recency.size() > capacity())
				void'(recency.pop_front());
		endfunction

		function void note_reference(page_t page);
			outcome_t o;
			int       slot;
			slot    = -1;
			o.flags = '0;
			o.victim = '0;
			foreach (recency[i])
				if (slot < 0 && recency[i] == page)
					slot = i;
			if (slot >= 0) begin
				o.flags.hit = 1'b1;
				recency.delete(slot);
			end else begin
				if (fault_total != FAULT_MAX)
					fault_total++;
				if (recency.size() >= capacity()) begin
					o.flags.evicted_valid = 1'b1;
					o.victim              = recency.pop_front();
				end
			end
			recency.push_back(page);
			o.faults = fault_total;
			awaited.push_back(o);
		endfunction

		function void check_outcome(logic hit_q, logic evicted_q, page_t victim_q,
				logic [FAULT_W-1:0] faults_q);
			outcome_t o;
			if (awaited.size() == 0) begin
				$error("unexpected result: hit=%0b evicted_valid=%0b evicted_page=%0h fault_count=%0d",
					hit_q, evicted_q, victim_q, faults_q);
				failures++;
				return;
			end
			o = awaited.pop_front();
			if (hit_q !== o.flags.hit) begin
				$error("hit: expected %0b, actual %0b", o.flags.hit, hit_q);
				failures++;
			end
			if (evicted_q !== o.flags.evicted_valid) begin
				$error("evicted_valid: expected %0b, actual %0b", o.flags.evicted_valid, evicted_q);
				failures++;
			end
			if (victim_q !== o.victim) begin
				$error("evicted_page: expected %0h, actual %0h", o.victim, victim_q);
				failures++;
			end
			if (faults_q !== o.faults) begin
				$error("fault_count: expected %0d, actual %0d", o.faults, faults_q);
				failures++;
			end
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	page_t              page_number;
	logic               out_valid;
	logic               out_ready;
	logic               hit;
	logic               evicted_valid;
	page_t              evicted_page;
	logic [FAULT_W-1:0] fault_count;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_frames;

	// when set, neither side idles: back-to-back transactions
	bit steady;

	lru_frame_board board;

	lru_page_replacement_unit #(
		.FRAMES    (FRAMES),
		.PAGE_WIDTH(PAGE_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_count  (fault_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.frame_count  (cfg_frames)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// Offer one reference after a random gap; valid stays up with the payload
	// held until the transaction goes through. Valid is left high on return so
	// the next call can follow with no gap.
	task automatic send_reference(page_t page);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		page_number <= page;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_reference(page);
	endtask

	// drop valid and wait until every reference has reported
	task automatic settle();
		in_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	// only written with the block idle
	task automatic write_frame_count(logic [CFG_W-1:0] value);
		settle();
		cfg_valid  <= 1'b1;
		cfg_frames <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.note_frame_count(value);
		cfg_valid <= 1'b0;
	endtask

	// Result side: check every accepted result, then hold ready low for a
	// random stall before taking the next one.
	initial begin : result_sink
		int unsigned stall;
		out_ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				board.check_outcome(hit, evicted_valid, evicted_page, fault_count);
				stall = steady ? 0 : $urandom_range(0, 8);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] phase_frames [PHASES-1];
		logic [CFG_W-1:0] setting;
		page_t            pool[$];
		int unsigned      pool_n;

		phase_frames = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd17, 5'd0, 5'd8, 5'd16, 5'd2, 5'd12,
			5'd5, 5'd9, 5'd31};
		board       = new();
		steady      = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		page_number <= '0;
		cfg_valid   <= 1'b0;
		cfg_frames  <= FRAME_COUNT_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, four frames out of reset: misses into empty frames, hit on
		// the least recent page, all-zero and all-one pages, hit on the most
		// recent page, then evictions once full.
		send_reference(16'h0000);
		send_reference(16'hFFFF);
		send_reference(16'h0000);
		send_reference(16'h5555);
		send_reference(16'hAAAA);
		send_reference(16'hAAAA);
		send_reference(16'h1234);
		send_reference(16'hFFFF);

		// zero frames acts as one; the write also trims three residents
		write_frame_count(5'd0);
		send_reference(16'hFFFF);
		send_reference(16'h0000);
		send_reference(16'h0000);

		write_frame_count(5'd2);
		send_reference(16'h8000);
		send_reference(16'h0001);
		send_reference(16'h8000);
		send_reference(16'h7FFE);

		// Random phases. Each draws a working set a bit larger than the frames so
		// hits, misses and evictions all keep coming; a few references fall
		// outside it. Phase order includes shrinks from full (16 -> 3, 31 -> 1)
		// and the out-of-range settings 0, 17 and 31.
		for (int ph = 0; ph < PHASES; ph++) begin
			setting = (ph < PHASES - 1) ? phase_frames[ph] : 5'($urandom_range(0, 31));
			write_frame_count(setting);
			steady = ($urandom_range(0, 4) == 0);
			pool_n = board.capacity() + $urandom_range(1, board.capacity() + 4);
			pool.delete();
			repeat (pool_n) pool.push_back(page_t'($urandom));
			for (int n = 0; n < PHASE_REFS; n++) begin
				if ($urandom_range(0, 99) < 90)
					send_reference(pool[$urandom_range(0, pool_n - 1)]);
				else
					send_reference(page_t'($urandom));
				// now and then let the pipe run dry mid-phase; the phase end
				// drains anyway
				if (n < PHASE_REFS - 1 && $urandom_range(0, 79) == 0)
					settle();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("lru_page_replacement_unit regression: pass");
		else
			$display("lru_page_replacement_unit regression: fail");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("lru_page_replacement_unit regression: fail");
		$finish;
	end

endmodule
